### hw/rtl/osbc_pkg.sv
package osbc_pkg;

    localparam int WordW = 64;
    localparam int ByteW = 8;

    localparam logic [WordW-1:0] HOST_CALL = '1;
    localparam logic [WordW-1:0] CALL_HALT = 64'd0;
    localparam logic [WordW-1:0] CALL_OUT  = 64'd1;
    localparam logic [WordW-1:0] CALL_IN   = 64'd2;

    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_READ   = 2'd1,
        REQ_STEP   = 2'd2,
        REQ_SET_IP = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        RUN_OK     = 2'd0,
        RUN_HALT   = 2'd1,
        RUN_MEMERR = 2'd2
    } t_run;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_DECODE,
        DP_HOST_RD,
        DP_CAP_A,
        DP_CAP_B,
        DP_CAP_C,
        DP_CAP_MB,
        DP_SUB,
        DP_LOAD_RSP
    } t_dp_op;

    typedef struct packed {
        logic   latch_req;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        t_req req_type;
        logic running;
        logic host;
    } t_dp_sts;

endpackage

### hw/rtl/osbc_if.sv
interface osbc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [63:0] addr;
    logic [63:0] data;
    logic [7:0]  in_byte;

    modport source (output valid, output req_type, output addr, output data,
                    output in_byte, input ready);
    modport sink (input valid, input req_type, input addr, input data,
                  input in_byte, output ready);
endinterface

interface osbc_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] read_data;
    logic [63:0] ip_now;
    logic [1:0]  run_status;
    logic        out_valid;
    logic [7:0]  out_byte;

    modport source (output valid, output read_data, output ip_now, output run_status,
                    output out_valid, output out_byte, input ready);
    modport sink (input valid, input read_data, input ip_now, input run_status,
                  input out_valid, input out_byte, output ready);
endinterface

### hw/rtl/osbc_ram.sv
module osbc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/osbc_ctrl.sv
module osbc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    input  osbc_pkg::t_dp_sts i_sts,
    output osbc_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [9:0] {
        S_CLEAR   = 10'b0000000001,
        S_IDLE    = 10'b0000000010,
        S_DECODE  = 10'b0000000100,
        S_HOST_RD = 10'b0000001000,
        S_CAP_A   = 10'b0000010000,
        S_CAP_B   = 10'b0000100000,
        S_CAP_C   = 10'b0001000000,
        S_CAP_MB  = 10'b0010000000,
        S_SUB     = 10'b0100000000,
        S_RESP    = 10'b1000000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_rsp_valid;
    logic   n_rsp_valid;
    logic   rsp_load;

    always_comb begin
        n_state         = r_state;
        o_cmd.latch_req = 1'b0;
        o_cmd.op        = osbc_pkg::DP_NOP;
        o_req_ready     = 1'b0;
        rsp_load        = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = osbc_pkg::DP_CLEAR;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_req_ready     = 1'b1;
                o_cmd.latch_req = i_req_valid;
                if (i_req_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.op = osbc_pkg::DP_DECODE;
                case (i_sts.req_type)
                    osbc_pkg::REQ_READ: n_state = S_HOST_RD;
                    osbc_pkg::REQ_STEP: n_state = i_sts.running ? S_CAP_A : S_RESP;
                    default:            n_state = S_RESP;
                endcase
            end
            S_HOST_RD: begin
                o_cmd.op = osbc_pkg::DP_HOST_RD;
                n_state  = S_RESP;
            end
            S_CAP_A: begin
                o_cmd.op = osbc_pkg::DP_CAP_A;
                n_state  = S_CAP_B;
            end
            S_CAP_B: begin
                o_cmd.op = osbc_pkg::DP_CAP_B;
                n_state  = S_CAP_C;
            end
            S_CAP_C: begin
                o_cmd.op = osbc_pkg::DP_CAP_C;
                n_state  = S_CAP_MB;
            end
            S_CAP_MB: begin
                o_cmd.op = osbc_pkg::DP_CAP_MB;
                n_state  = i_sts.host ? S_RESP : S_SUB;
            end
            S_SUB: begin
                o_cmd.op = osbc_pkg::DP_SUB;
                n_state  = S_RESP;
            end
            S_RESP: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    o_cmd.op = osbc_pkg::DP_LOAD_RSP;
                    rsp_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_rsp_valid = (r_rsp_valid && !i_rsp_ready) || rsp_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_rsp_valid = r_rsp_valid;

endmodule

### hw/rtl/osbc_datapath.sv
module osbc_datapath #(
    parameter int MEM_WORDS = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  osbc_pkg::t_dp_cmd i_cmd,
    output osbc_pkg::t_dp_sts o_sts,
    input  logic [1:0]        i_req_type,
    input  logic [63:0]       i_addr,
    input  logic [63:0]       i_data,
    input  logic [7:0]        i_in_byte,
    output logic [63:0]       o_read_data,
    output logic [63:0]       o_ip_now,
    output logic [1:0]        o_run_status,
    output logic              o_out_valid,
    output logic [7:0]        o_out_byte
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [AW-1:0] LastWord = AW'(MEM_WORDS - 1);
    localparam logic [63:0] MemSize = 64'(MEM_WORDS);

    osbc_pkg::t_req   r_req_type;
    logic [63:0]      r_addr;
    logic [63:0]      r_data;
    logic [7:0]       r_in_byte;
    logic [63:0]      r_ip;
    logic [63:0]      n_ip;
    osbc_pkg::t_run   r_status;
    osbc_pkg::t_run   n_status;
    logic [AW-1:0]    r_clr;
    logic [63:0]      r_a;
    logic [63:0]      r_b;
    logic [63:0]      r_c;
    logic [63:0]      r_mb;
    logic [63:0]      r_rd;
    logic             r_ov;
    logic [7:0]       r_ob;
    logic             r_rd_ok;
    logic [63:0]      r_rsp_rd;
    logic [63:0]      r_rsp_ip;
    logic [1:0]       r_rsp_status;
    logic             r_rsp_ov;
    logic [7:0]       r_rsp_ob;

    logic [63:0]      m_addr;
    logic             m_we;
    logic [63:0]      m_wdata;
    logic             m_in;
    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    logic [63:0]      ram_q;
    logic [63:0]      q;
    logic             host;
    logic [63:0]      ip_plus3;

    assign host     = (r_a == osbc_pkg::HOST_CALL);
    assign ip_plus3 = r_ip + 64'd3;
    assign q        = r_rd_ok ? ram_q : 64'd0;

    always_comb begin
        m_addr  = r_ip;
        m_we    = 1'b0;
        m_wdata = 64'd0;
        case (i_cmd.op)
            osbc_pkg::DP_DECODE: begin
                case (r_req_type)
                    osbc_pkg::REQ_WRITE: begin
                        m_addr  = r_addr;
                        m_we    = 1'b1;
                        m_wdata = r_data;
                    end
                    osbc_pkg::REQ_READ: m_addr = r_addr;
                    default:            m_addr = r_ip;
                endcase
            end
            osbc_pkg::DP_CAP_A: m_addr = r_ip + 64'd1;
            osbc_pkg::DP_CAP_B: m_addr = r_ip + 64'd2;
            osbc_pkg::DP_CAP_C: m_addr = r_b;
            osbc_pkg::DP_CAP_MB: begin
                if (host) begin
                    m_addr  = r_b;
                    m_we    = (r_c == osbc_pkg::CALL_IN);
                    m_wdata = {56'd0, r_in_byte};
                end else begin
                    m_addr = r_a;
                end
            end
            osbc_pkg::DP_SUB: begin
                m_addr  = r_a;
                m_we    = 1'b1;
                m_wdata = q - r_mb;
            end
            default: begin
                m_addr = r_ip;
            end
        endcase
    end

    assign m_in     = (m_addr < MemSize);
    assign ram_we   = (i_cmd.op == osbc_pkg::DP_CLEAR) || (m_we && m_in);
    assign ram_addr = (i_cmd.op == osbc_pkg::DP_CLEAR) ? r_clr : m_addr[AW-1:0];

    osbc_ram #(
        .WIDTH(64),
        .DEPTH(MEM_WORDS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata((i_cmd.op == osbc_pkg::DP_CLEAR) ? 64'd0 : m_wdata),
        .o_rdata(ram_q)
    );

    always_comb begin
        n_ip     = r_ip;
        n_status = r_status;
        if (m_we && !m_in && (m_wdata != 64'd0)) begin
            n_status = osbc_pkg::RUN_MEMERR;
        end
        case (i_cmd.op)
            osbc_pkg::DP_DECODE: begin
                if (r_req_type == osbc_pkg::REQ_SET_IP) begin
                    n_ip = r_data;
                end
            end
            osbc_pkg::DP_CAP_MB: begin
                if (host) begin
                    n_ip = ip_plus3;
                    if (r_c == osbc_pkg::CALL_HALT) begin
                        n_status = osbc_pkg::RUN_HALT;
                    end
                end
            end
            osbc_pkg::DP_SUB: begin
                n_ip = (q <= r_mb) ? r_c : ip_plus3;
            end
            default: begin
                n_ip = r_ip;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip     <= 64'd0;
            r_status <= osbc_pkg::RUN_OK;
            r_clr    <= '0;
        end else begin
            r_ip     <= n_ip;
            r_status <= n_status;
            if (i_cmd.op == osbc_pkg::DP_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ok <= m_in;
        if (i_cmd.latch_req) begin
            r_req_type <= osbc_pkg::t_req'(i_req_type);
            r_addr     <= i_addr;
            r_data     <= i_data;
            r_in_byte  <= i_in_byte;
        end
        case (i_cmd.op)
            osbc_pkg::DP_DECODE: begin
                r_rd <= 64'd0;
                r_ov <= 1'b0;
                r_ob <= 8'd0;
            end
            osbc_pkg::DP_HOST_RD: r_rd <= q;
            osbc_pkg::DP_CAP_A:   r_a  <= q;
            osbc_pkg::DP_CAP_B:   r_b  <= q;
            osbc_pkg::DP_CAP_C:   r_c  <= q;
            osbc_pkg::DP_CAP_MB: begin
                r_mb <= q;
            end
            osbc_pkg::DP_LOAD_RSP: begin
                r_rsp_rd     <= r_rd;
                r_rsp_ip     <= r_ip;
                r_rsp_status <= r_status;
                r_rsp_ov     <= r_ov;
                r_rsp_ob     <= r_ob;
            end
            default: begin
            end
        endcase
        if (i_cmd.op == osbc_pkg::DP_CAP_MB && host && r_c == osbc_pkg::CALL_OUT) begin
            r_ov <= 1'b1;
            r_ob <= q[7:0];
        end
    end

    assign o_sts.clr_done = (r_clr == LastWord);
    assign o_sts.req_type = r_req_type;
    assign o_sts.running  = (r_status == osbc_pkg::RUN_OK);
    assign o_sts.host     = host;

    assign o_read_data  = r_rsp_rd;
    assign o_ip_now     = r_rsp_ip;
    assign o_run_status = r_rsp_status;
    assign o_out_valid  = r_rsp_ov;
    assign o_out_byte   = r_rsp_ob;

endmodule

### hw/rtl/one_instruction_subtract_branch_core.sv
// A subtract-and-branch machine with 64-bit words and a word memory of MEM_WORDS entries
// on a single memory port. After reset the block clears the memory one word a cycle, so
// it takes no request until every word is cleared. Every request gives one response.
// From acceptance the controller passes through S_DECODE and S_RESP for a write or a
// set, S_DECODE, S_HOST_RD and S_RESP for a read, and S_DECODE, S_CAP_A, S_CAP_B,
// S_CAP_C, S_CAP_MB, S_SUB and S_RESP for a subtracting step; a host call step skips
// S_SUB. A subtracting step makes five dependent reads (A, B, C, mem[B], mem[A]) and
// one write-back, one access a cycle through the memory port, and that port sets the
// step time. A step while the machine is not running goes from S_DECODE to S_RESP. The
// response sits in an output register; a new request is taken the cycle after it is loaded.
module one_instruction_subtract_branch_core #(
    parameter int MEM_WORDS = 4096
) (
    input logic        i_clk,
    input logic        i_rst_n,
    osbc_req_if.sink   i_req,
    osbc_rsp_if.source o_rsp
);

    osbc_pkg::t_dp_cmd cmd;
    osbc_pkg::t_dp_sts sts;

    osbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req.valid),
        .o_req_ready(i_req.ready),
        .o_rsp_valid(o_rsp.valid),
        .i_rsp_ready(o_rsp.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    osbc_datapath #(
        .MEM_WORDS(MEM_WORDS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req_type  (i_req.req_type),
        .i_addr      (i_req.addr),
        .i_data      (i_req.data),
        .i_in_byte   (i_req.in_byte),
        .o_read_data (o_rsp.read_data),
        .o_ip_now    (o_rsp.ip_now),
        .o_run_status(o_rsp.run_status),
        .o_out_valid (o_rsp.out_valid),
        .o_out_byte  (o_rsp.out_byte)
    );

endmodule
